// ----- design/assert_macros.svh -----
// Assertion macros for the list engine's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ----- design/ile_pkg.sv -----
// Types and constants shared by the indexed list engine.
package ile_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic signed [DATA_W-1:0] NOT_FOUND_VALUE = -32'sd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_EDIT   = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_GET    = 3'd4,
    KIND_FIND   = 3'd5
  } op_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_WRITE,
    CELL_PULL
  } cell_op_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_op_t                  op;
    logic [CNT_W-1:0]          pivot;
    logic signed [DATA_W-1:0]  value;
    logic [CNT_W-1:0]          count;
  } cell_ctl_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  read_value;
    logic [CNT_W-1:0]          entry_count;
    logic                      empty_flag;
    logic                      full_flag;
  } rsp_t;

endpackage

// ----- design/ile_cell.sv -----
// One storage cell of the list chain: holds one entry and trades with its neighbors.
module ile_cell import ile_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     match
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH: begin
        // Entries above the insertion point move up by one place.
        if (IDX > ctl.pivot) begin
          data <= left_data;
        end else if (IDX == ctl.pivot) begin
          data <= ctl.value;
        end
      end
      CELL_WRITE: begin
        if (IDX == ctl.pivot) begin
          data <= ctl.value;
        end
      end
      CELL_PULL: begin
        // The deleted entry and everything above it take the next entry up.
        if (IDX >= ctl.pivot) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign match = (data == ctl.value) && (IDX < ctl.count);

endmodule

// ----- design/ile_first_match.sv -----
// Two-level first-match search over the cells' match bits, first level registered.
module ile_first_match #(
  parameter  int WIDTH  = 64,
  localparam int GROUPS = (WIDTH + 7) / 8,
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int IDX_W  = GRP_W + 3
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] match,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  logic [GROUPS*8-1:0] padded;
  logic [GROUPS-1:0]   grp_any_next;
  logic [2:0]          grp_idx_next [GROUPS];
  logic [GROUPS-1:0]   grp_any;
  logic [2:0]          grp_idx [GROUPS];

  assign padded = (GROUPS*8)'(match);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_any_next[g] = |padded[g*8 +: 8];
      grp_idx_next[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (padded[g*8 + b]) begin
          grp_idx_next[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
    for (int g = 0; g < GROUPS; g++) begin
      grp_idx[g] <= grp_idx_next[g];
    end
  end

  // The lowest group with a hit wins.
  always_comb begin
    found = 1'b0;
    index = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        found = 1'b1;
        index = {GRP_W'(g), grp_idx[g]};
      end
    end
  end

endmodule

// ----- design/indexed_list_engine.sv -----
// A request passes through the execute, scan and pick states before its response is
// offered, and a new request is taken only back in idle; execute updates the cells and
// also registers a copy of the match bits, which feeds a two-level first-match search whose
// first level is registered. Reset clears the entry count and the control state;
// cell contents are not cleared and are only read below the count.
`include "assert_macros.svh"

module indexed_list_engine import ile_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // DEPTH ranges from 2 to 64, the span of the position field.
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IW     = $clog2(DEPTH);
  localparam int GROUPS = (DEPTH + 7) / 8;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int FM_W   = GRP_W + 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK
  } state_t;

  state_t                   state;
  req_t                     req_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [DEPTH-1:0]         match_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     is_find_q;

  cell_ctl_t                ctl;
  cell_ctl_t                exec_ctl;
  logic [STAT_W-1:0]        exec_status;
  logic signed [DATA_W-1:0] exec_value;
  logic [CNT_W-1:0]         pos_ext;
  logic [CNT_W-1:0]         count_ext;
  logic                     pos_ok;
  logic                     is_full;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_match;
  logic                     fm_found;
  logic [FM_W-1:0]          fm_index;

  assign req_ready = (state == S_IDLE);
  assign pos_ext   = CNT_W'(req_q.position);
  assign count_ext = CNT_W'(count);
  assign pos_ok    = pos_ext < count_ext;
  assign is_full   = (count == CW'(DEPTH));

  always_comb begin
    exec_ctl.op    = CELL_HOLD;
    exec_ctl.pivot = pos_ext;
    exec_ctl.value = req_q.item_value;
    exec_ctl.count = count_ext;
    exec_status    = ST_OK;
    exec_value     = '0;
    count_next     = count;
    unique case (op_kind_t'(req_q.kind))
      KIND_APPEND, KIND_INSERT: begin
        if (is_full) begin
          exec_status = ST_FULL;
        end else begin
          exec_ctl.op = CELL_PUSH;
          // Append, or an insert past the end, lands right after the last entry.
          if (op_kind_t'(req_q.kind) == KIND_APPEND || !pos_ok) begin
            exec_ctl.pivot = count_ext;
          end
          count_next = count + CW'(1);
        end
      end
      KIND_EDIT: begin
        if (pos_ok) begin
          exec_ctl.op = CELL_WRITE;
        end else begin
          exec_status = ST_BAD_INDEX;
        end
      end
      KIND_DELETE: begin
        if (pos_ok) begin
          exec_ctl.op = CELL_PULL;
          count_next  = count - CW'(1);
        end else begin
          exec_status = ST_BAD_INDEX;
        end
      end
      KIND_GET: begin
        if (pos_ok) begin
          exec_value = cell_data[req_q.position[IW-1:0]];
        end else begin
          exec_status = ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl = exec_ctl;
    if (state != S_EXEC) begin
      ctl.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ile_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  ile_first_match #(
    .WIDTH(DEPTH)
  ) u_first_match (
    .clk  (clk),
    .match(match_q),
    .found(fm_found),
    .index(fm_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In the pick cycle a departing response is replaced by the new one below.
      if (rsp_valid && rsp_ready && state != S_PICK) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count     <= count_next;
          match_q   <= cell_match;
          status_q  <= exec_status;
          value_q   <= exec_value;
          is_find_q <= (op_kind_t'(req_q.kind) == KIND_FIND);
          state     <= S_SCAN;
        end
        S_SCAN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (!rsp_valid || rsp_ready) begin
            if (is_find_q) begin
              rsp.status     <= fm_found ? ST_OK : ST_NOT_FOUND;
              rsp.read_value <= fm_found ? DATA_W'(fm_index) : NOT_FOUND_VALUE;
            end else begin
              rsp.status     <= status_q;
              rsp.read_value <= value_q;
            end
            rsp.entry_count <= CNT_W'(count);
            rsp.empty_flag  <= (count == '0);
            rsp.full_flag   <= is_full;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_range, count <= CW'(DEPTH), "entry count above capacity")
  `ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state == S_EXEC, "request did not start")
  `ASSERT_NEXT(a_count_exec_only, state != S_EXEC, $stable(count), "count moved outside execute")
  `ASSERT_NEXT(a_count_step, state == S_EXEC, (count == $past(count)) || (count == $past(count) + CW'(1)) || (count + CW'(1) == $past(count)), "count moved by more than one")

endmodule

// ----- tb/sv/indexed_list_engine_test.sv -----
// Self-checking testbench for the indexed list engine with a queue-fed driver and a response monitor.
module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int RANDOM_ITEMS = 525;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic req_accepted = 1'b0;
  int sent_count = 0;
  int phase_len = 1;
  int send_idle_pct = 0;
  int take_stall_pct = 0;
  int stall_cycles = 0;
  int error_count = 0;
  int gen_len = 0;

  // Predicted contents of the list.
  logic signed [DATA_W-1:0] list_store [LIST_DEPTH];
  int list_len = 0;

  indexed_list_engine #(.DEPTH(LIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t res;
    int at;
    res = '0;
    res.status = ST_OK;
    case (r.kind)
      KIND_APPEND, KIND_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          at = (r.kind == KIND_INSERT && int'(r.position) < list_len) ? int'(r.position) : list_len;
          for (int i = list_len; i > at; i--) list_store[i] = list_store[i-1];
          list_store[at] = r.item_value;
          list_len++;
        end
      end
      KIND_EDIT: begin
        if (int'(r.position) >= list_len) res.status = ST_BAD_INDEX;
        else list_store[r.position] = r.item_value;
      end
      KIND_DELETE: begin
        if (int'(r.position) >= list_len) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int i = r.position; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
      KIND_GET: begin
        if (int'(r.position) >= list_len) res.status = ST_BAD_INDEX;
        else res.read_value = list_store[r.position];
      end
      KIND_FIND: begin
        res.status = ST_NOT_FOUND;
        res.read_value = NOT_FOUND_VALUE;
        for (int i = 0; i < list_len; i++) begin
          if (list_store[i] == r.item_value) begin
            res.status = ST_OK;
            res.read_value = i;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_W'(list_len);
    res.empty_flag = (list_len == 0);
    res.full_flag = (list_len == LIST_DEPTH);
    return res;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  task automatic check_response(rsp_t got);
    rsp_t want;
    if (expected_rsps.size() == 0) begin
      $display("%0t: response with none expected: status %0d, value %0d, count %0d",
               $time, got.status, got.read_value, got.entry_count);
      error_count++;
    end else begin
      want = expected_rsps.pop_front();
      if (got.status !== want.status) report_mismatch("status", want.status, got.status);
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", want.read_value, got.read_value);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", want.entry_count, got.entry_count);
      if (got.empty_flag !== want.empty_flag)
        report_mismatch("empty_flag", want.empty_flag, got.empty_flag);
      if (got.full_flag !== want.full_flag)
        report_mismatch("full_flag", want.full_flag, got.full_flag);
    end
  endtask

  // Queues a request and tracks the list length so that later positions can aim inside it.
  task automatic add_request(logic [KIND_W-1:0] kind, int pos, logic signed [DATA_W-1:0] value);
    req_t r;
    r.kind = kind;
    r.position = pos[POS_W-1:0];
    r.item_value = value;
    pending_reqs.push_back(r);
    if ((kind == KIND_APPEND || kind == KIND_INSERT) && gen_len < LIST_DEPTH) gen_len++;
    else if (kind == KIND_DELETE && r.position < gen_len) gen_len--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 50) return $signed($urandom_range(15)) - 8;
    return $urandom;
  endfunction

  function automatic int pick_position();
    if (gen_len > 0 && $urandom_range(99) < 80) return $urandom_range(gen_len - 1);
    return $urandom_range(63);
  endfunction

  task automatic add_random_requests();
    bit growing;
    int full_hits;
    int roll;
    growing = 1'b1;
    full_hits = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate between filling the list past full and draining it to empty.
      if (gen_len == LIST_DEPTH && growing) begin
        full_hits++;
        if (full_hits > 6) begin
          growing = 1'b0;
          full_hits = 0;
        end
      end else if (gen_len == 0) begin
        growing = 1'b1;
      end
      roll = $urandom_range(99);
      if ($urandom_range(99) < 8) begin
        add_request(KIND_W'($urandom_range(7)), $urandom_range(63), $urandom);
      end else if (roll < (growing ? 35 : 12)) begin
        add_request(KIND_APPEND, $urandom_range(63), pick_value());
      end else if (roll < (growing ? 65 : 24)) begin
        add_request(KIND_INSERT, pick_position(), pick_value());
      end else if (roll < (growing ? 75 : 64)) begin
        add_request(KIND_DELETE, pick_position(), pick_value());
      end else if (roll < (growing ? 82 : 74)) begin
        add_request(KIND_EDIT, pick_position(), pick_value());
      end else if (roll < (growing ? 91 : 87)) begin
        add_request(KIND_GET, pick_position(), pick_value());
      end else begin
        add_request(KIND_FIND, pick_position(), pick_value());
      end
    end
  endtask

  initial begin
    // Requests against an empty list.
    add_request(KIND_GET, 0, 32'sd0);
    add_request(KIND_DELETE, 0, 32'sd0);
    add_request(KIND_EDIT, 0, 32'sd5);
    add_request(KIND_FIND, 63, 32'sd5);
    // Extreme values, inserts at front, middle and past end, then gets, edits, finds, deletes.
    add_request(KIND_APPEND, 0, 32'sh7FFF_FFFF);
    add_request(KIND_APPEND, 63, 32'sh8000_0000);
    add_request(KIND_APPEND, 0, 32'sd0);
    add_request(KIND_APPEND, 0, -32'sd1);
    add_request(KIND_INSERT, 0, 32'sd11);
    add_request(KIND_INSERT, 2, 32'sd22);
    add_request(KIND_INSERT, 63, 32'sd33);
    add_request(KIND_GET, 0, 32'sd0);
    add_request(KIND_GET, 6, 32'sd0);
    add_request(KIND_GET, 63, 32'sd0);
    add_request(KIND_EDIT, 1, 32'sd44);
    add_request(KIND_EDIT, 63, 32'sd55);
    add_request(KIND_FIND, 0, 32'sd33);
    add_request(KIND_FIND, 0, 32'sd99);
    add_request(KIND_FIND, 0, -32'sd1);
    add_request(KIND_DELETE, 0, 32'sd0);
    add_request(KIND_DELETE, 2, 32'sd0);
    add_request(KIND_DELETE, 4, 32'sd0);
    add_request(KIND_UNUSED_6, 42, 32'sh5A5A_A5A5);
    add_request(KIND_UNUSED_7, 21, -32'sd77);
    add_random_requests();
    phase_len = pending_reqs.size() / 3;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** indexed_list_engine: PASSED **");
    end else begin
      $display("** indexed_list_engine: FAILED **");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (sent_count < phase_len) begin
        send_idle_pct = 26;
        take_stall_pct = 69;
      end else if (sent_count < 2 * phase_len) begin
        send_idle_pct = 69;
        take_stall_pct = 26;
      end else begin
        send_idle_pct = 0;
        take_stall_pct = 0;
      end
      if (!req_valid || req_accepted) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          sent_count++;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_accepted <= 1'b0;
      stall_cycles = 0;
    end else begin
      req_accepted <= req_valid && req_ready;
      if (req_valid && req_ready) expected_rsps.push_back(apply_list_op(req));
      if (rsp_valid && rsp_ready) check_response(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
        $display("** indexed_list_engine: FAILED **");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ile_pkg.sv
design/ile_cell.sv
design/ile_first_match.sv
design/indexed_list_engine.sv
tb/sv/indexed_list_engine_test.sv
